/* hdl/ccrc_pkg.sv */
// Shared types, constants and helper functions for the configurable CRC engine.
// Depends on nothing; every other file in the project imports this package.
package ccrc_pkg;

   localparam int CrcMaxWidth = 64;
   localparam int WidthBits   = $clog2(CrcMaxWidth) + 1;
   localparam int RegWidthBits = 7;
   localparam int ByteBits    = 8;
   localparam int CsrAddrBits = 6;
   localparam int CsrDataBits = 64;

   typedef logic [CrcMaxWidth-1:0]  crc_word_type;
   typedef logic [WidthBits-1:0]    width_type;
   typedef logic [ByteBits-1:0]     byte_type;

   typedef enum logic [2:0] {
      CSR_CRC_WIDTH      = 3'd0,
      CSR_GENERATOR_POLY = 3'd1,
      CSR_START_VALUE    = 3'd2,
      CSR_REVERSE_INPUT  = 3'd3,
      CSR_REVERSE_OUTPUT = 3'd4,
      CSR_FINAL_XOR      = 3'd5
   } csr_reg_type;

   localparam logic [RegWidthBits-1:0] CrcWidthReset  = 7'd32;
   localparam crc_word_type            PolyReset      = 64'h0000_0000_04C1_1DB7;
   localparam crc_word_type            StartReset     = 64'h0000_0000_FFFF_FFFF;
   localparam logic                    RevInReset     = 1'b1;
   localparam logic                    RevOutReset    = 1'b1;
   localparam crc_word_type            FinalXorReset  = 64'h0000_0000_FFFF_FFFF;
   localparam crc_word_type            RunningReset   = 64'h0000_0000_FFFF_FFFF;

   // Configuration as seen by the datapath, already clamped and masked.
   typedef struct packed {
      width_type    width;
      crc_word_type mask;
      crc_word_type top;
      crc_word_type poly;
      crc_word_type start;
      crc_word_type final_xor;
      logic         rev_in;
      logic         rev_out;
   } cfg_type;

   // Contents of the input register.
   typedef struct packed {
      logic         use_load;
      crc_word_type load_value;
      crc_word_type data_shifted;
      logic         last;
   } load_type;

   function automatic width_type clamp_width(logic [RegWidthBits-1:0] raw);
      width_type w;
      w = width_type'(raw);
      if (raw < RegWidthBits'(ByteBits)) begin
         w = width_type'(ByteBits);
      end else if (raw > RegWidthBits'(CrcMaxWidth)) begin
         w = width_type'(CrcMaxWidth);
      end
      return w;
   endfunction

   function automatic crc_word_type width_mask(width_type w);
      return {CrcMaxWidth{1'b1}} >> (width_type'(CrcMaxWidth) - w);
   endfunction

   function automatic crc_word_type reflect_width(crc_word_type v, width_type w);
      crc_word_type full;
      for (int i = 0; i < CrcMaxWidth; i++) begin
         full[i] = v[CrcMaxWidth-1-i];
      end
      return full >> (width_type'(CrcMaxWidth) - w);
   endfunction

   function automatic byte_type reflect_byte(byte_type v);
      byte_type r;
      for (int i = 0; i < ByteBits; i++) begin
         r[i] = v[ByteBits-1-i];
      end
      return r;
   endfunction

endpackage

/* hdl/ccrc_ifs.sv */
// Request and result channel interfaces of the configurable CRC engine.
// Depends on ccrc_pkg for the payload types.
interface ccrc_req_if import ccrc_pkg::*; ();
   logic         valid;
   logic         ready;
   byte_type     data_byte;
   logic         begin_fresh;
   logic         begin_resume;
   crc_word_type prior_result;
   logic         last_byte;

   modport source (output valid, data_byte, begin_fresh, begin_resume, prior_result,
                   last_byte, input ready);
   modport sink (input valid, data_byte, begin_fresh, begin_resume, prior_result,
                 last_byte, output ready);
endinterface

interface ccrc_rsp_if import ccrc_pkg::*; ();
   logic         valid;
   logic         ready;
   crc_word_type crc_result;

   modport source (output valid, crc_result, input ready);
   modport sink (input valid, crc_result, output ready);
endinterface

/* hdl/ccrc_csr.sv */
// Configuration register bank with its APB-style port and the derived datapath settings.
// Depends on ccrc_pkg.
module ccrc_csr import ccrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [CsrDataBits-1:0] pwdata,
   output logic [CsrDataBits-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [RegWidthBits-1:0] crc_width_ff, crc_width_in;
   crc_word_type            poly_ff, poly_in;
   crc_word_type            start_ff, start_in;
   logic                    rev_in_ff, rev_in_in;
   logic                    rev_out_ff, rev_out_in;
   crc_word_type            final_xor_ff, final_xor_in;
   logic                    write_en;
   csr_reg_type             reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign reg_sel  = csr_reg_type'(paddr[CsrAddrBits-1:3]);

   always_comb begin
      crc_width_in = crc_width_ff;
      poly_in      = poly_ff;
      start_in     = start_ff;
      rev_in_in    = rev_in_ff;
      rev_out_in   = rev_out_ff;
      final_xor_in = final_xor_ff;
      if (write_en) begin
         case (reg_sel)
            CSR_CRC_WIDTH: begin
               crc_width_in = pwdata[RegWidthBits-1:0];
            end
            CSR_GENERATOR_POLY: begin
               poly_in = pwdata;
            end
            CSR_START_VALUE: begin
               start_in = pwdata;
            end
            CSR_REVERSE_INPUT: begin
               rev_in_in = pwdata[0];
            end
            CSR_REVERSE_OUTPUT: begin
               rev_out_in = pwdata[0];
            end
            CSR_FINAL_XOR: begin
               final_xor_in = pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_width_ff <= CrcWidthReset;
         poly_ff      <= PolyReset;
         start_ff     <= StartReset;
         rev_in_ff    <= RevInReset;
         rev_out_ff   <= RevOutReset;
         final_xor_ff <= FinalXorReset;
      end else begin
         crc_width_ff <= crc_width_in;
         poly_ff      <= poly_in;
         start_ff     <= start_in;
         rev_in_ff    <= rev_in_in;
         rev_out_ff   <= rev_out_in;
         final_xor_ff <= final_xor_in;
      end
   end

   always_comb begin
      case (reg_sel)
         CSR_CRC_WIDTH: begin
            prdata = CsrDataBits'(crc_width_ff);
         end
         CSR_GENERATOR_POLY: begin
            prdata = poly_ff;
         end
         CSR_START_VALUE: begin
            prdata = start_ff;
         end
         CSR_REVERSE_INPUT: begin
            prdata = CsrDataBits'(rev_in_ff);
         end
         CSR_REVERSE_OUTPUT: begin
            prdata = CsrDataBits'(rev_out_ff);
         end
         CSR_FINAL_XOR: begin
            prdata = final_xor_ff;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_comb begin
      cfg.width     = clamp_width(crc_width_ff);
      cfg.mask      = width_mask(cfg.width);
      cfg.top       = crc_word_type'(1) << (cfg.width - width_type'(1));
      cfg.poly      = poly_ff & cfg.mask;
      cfg.start     = start_ff & cfg.mask;
      cfg.final_xor = final_xor_ff & cfg.mask;
      cfg.rev_in    = rev_in_ff;
      cfg.rev_out   = rev_out_ff;
   end

endmodule

/* hdl/ccrc_load.sv */
// Input register: takes a request, reflects and aligns the byte, and prepares the start or
// resumed register value. Depends on ccrc_pkg and ccrc_req_if.
module ccrc_load import ccrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ccrc_req_if.sink   req_chan,
   input  cfg_type    cfg,
   input  logic       load_take,
   output logic       load_valid,
   output load_type   load_data
);

   logic         load_valid_ff, load_valid_in;
   load_type     load_data_ff, load_data_in;
   logic         accept;
   byte_type     data_byte;
   crc_word_type prior_raw;
   crc_word_type prior_value;

   assign req_chan.ready = !load_valid_ff || load_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      data_byte   = cfg.rev_in ? reflect_byte(req_chan.data_byte) : req_chan.data_byte;
      prior_raw   = (req_chan.prior_result & cfg.mask) ^ cfg.final_xor;
      prior_value = cfg.rev_out ? reflect_width(prior_raw, cfg.width) : prior_raw;

      load_data_in.use_load     = req_chan.begin_fresh || req_chan.begin_resume;
      load_data_in.load_value   = req_chan.begin_fresh ? cfg.start : prior_value;
      load_data_in.data_shifted = crc_word_type'(data_byte) << (cfg.width - width_type'(ByteBits));
      load_data_in.last         = req_chan.last_byte;

      load_valid_in = accept || (load_valid_ff && !load_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_valid_ff <= 1'b0;
      end else begin
         load_valid_ff <= load_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         load_data_ff <= load_data_in;
      end
   end

   assign load_valid = load_valid_ff;
   assign load_data  = load_data_ff;

endmodule

/* hdl/ccrc_step.sv */
// Eight-bit polynomial advance and the running CRC register.
// Depends on ccrc_pkg.
module ccrc_step import ccrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         load_valid,
   input  load_type     load_data,
   output logic         load_take,
   input  logic         fin_ready,
   output logic         fin_valid,
   output crc_word_type fin_crc
);

   crc_word_type running_ff, running_in;
   crc_word_type crc_next;

   assign load_take = load_valid && (!load_data.last || fin_ready);
   assign fin_valid = load_valid && load_data.last;
   assign fin_crc   = crc_next;

   always_comb begin
      crc_word_type c;
      c = load_data.use_load ? load_data.load_value : (running_ff & cfg.mask);
      c = c ^ load_data.data_shifted;
      for (int k = 0; k < ByteBits; k++) begin
         if (|(c & cfg.top)) begin
            c = ((c << 1) ^ cfg.poly) & cfg.mask;
         end else begin
            c = (c << 1) & cfg.mask;
         end
      end
      crc_next = c;
   end

   always_comb begin
      running_in = running_ff;
      if (load_take) begin
         running_in = load_data.last ? cfg.start : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= RunningReset;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule

/* hdl/ccrc_final.sv */
// Holding register for a completed CRC, finalisation logic and the result register.
// Depends on ccrc_pkg and ccrc_rsp_if.
module ccrc_final import ccrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         fin_valid,
   input  crc_word_type fin_crc,
   output logic         fin_ready,
   ccrc_rsp_if.source   rsp_chan
);

   logic         hold_valid_ff, hold_valid_in;
   crc_word_type hold_crc_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   crc_word_type rsp_crc_ff, rsp_crc_in;
   logic         rsp_free;
   logic         hold_move;
   logic         fin_accept;
   crc_word_type ordered;

   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign hold_move  = hold_valid_ff && rsp_free;
   assign fin_ready  = !hold_valid_ff || hold_move;
   assign fin_accept = fin_valid && fin_ready;

   always_comb begin
      ordered       = cfg.rev_out ? reflect_width(hold_crc_ff, cfg.width) : hold_crc_ff;
      rsp_crc_in    = (ordered ^ cfg.final_xor) & cfg.mask;
      hold_valid_in = fin_accept || (hold_valid_ff && !hold_move);
      rsp_valid_in  = hold_move || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_accept) begin
         hold_crc_ff <= fin_crc;
      end
      if (hold_move) begin
         rsp_crc_ff <= rsp_crc_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.crc_result = rsp_crc_ff;

endmodule

/* hdl/configurable_crc_engine.sv */
// Configurable CRC engine, widths 8 to 64, one request byte absorbed per clock cycle.
// Throughput is one request per cycle; both hold only while no last byte waits for a full
// holding register. The eight polynomial steps are one XOR network between the input register
// and the running CRC register. A last byte passes the input register, the holding register
// and the result register, each of which can stall. Synchronous active-high reset empties all
// stages, loads the reset configuration and sets the running CRC to the masked start value.
// Depends on ccrc_pkg and the channel interfaces.
module configurable_crc_engine import ccrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ccrc_req_if.sink               req_chan,
   ccrc_rsp_if.source             rsp_chan,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [CsrDataBits-1:0] pwdata,
   output logic [CsrDataBits-1:0] prdata,
   output logic                   pready
);

   cfg_type      cfg;
   logic         load_valid;
   load_type     load_data;
   logic         load_take;
   logic         fin_ready;
   logic         fin_valid;
   crc_word_type fin_crc;

   ccrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ccrc_load u_load (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .load_take  (load_take),
      .load_valid (load_valid),
      .load_data  (load_data)
   );

   ccrc_step u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .load_valid (load_valid),
      .load_data  (load_data),
      .load_take  (load_take),
      .fin_ready  (fin_ready),
      .fin_valid  (fin_valid),
      .fin_crc    (fin_crc)
   );

   ccrc_final u_final (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fin_valid (fin_valid),
      .fin_crc   (fin_crc),
      .fin_ready (fin_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
